// ===== rtl/wgrl_pkg.sv =====
// ----------------------------------------------------------------------------
// wgrl_pkg
// Shared sizes, types and the tile edge decode for the walled grid route load.
// ----------------------------------------------------------------------------
package wgrl_pkg;

   localparam int GRID_SIDE = 4;
   localparam int TILES     = GRID_SIDE * GRID_SIDE;
   localparam int VERT_BITS = GRID_SIDE * (GRID_SIDE - 1);
   localparam int FAR_HOPS  = TILES + 4;
   localparam int LAYOUT_W  = 24;
   localparam int TILE_W    = $clog2(TILES);
   localparam int DIST_W    = $clog2(FAR_HOPS + 1);
   localparam int CNT_W     = $clog2(TILES + 1);
   localparam int LOAD_W    = $clog2(TILES * (TILES - 1) + 1);
   localparam int REACH_W   = 5;
   localparam int PEAK_W    = 9;

   localparam logic [2:0] OP_HOLD  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_INIT  = 3'd2;
   localparam logic [2:0] OP_RELAX = 3'd3;
   localparam logic [2:0] OP_COUNT = 3'd4;
   localparam logic [2:0] OP_ACC   = 3'd5;

   localparam logic [1:0] DIR_N = 2'd0;
   localparam logic [1:0] DIR_E = 2'd1;
   localparam logic [1:0] DIR_S = 2'd2;
   localparam logic [1:0] DIR_W = 2'd3;

   typedef logic [DIST_W-1:0] dist_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [LOAD_W-1:0] load_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] dir;
   } hop_type;

   typedef struct packed {
      logic [2:0]        op;
      logic [TILE_W-1:0] dest;
   } cell_cmd_type;

   function automatic logic wall_at(logic [LAYOUT_W-1:0] layout, int k);
      if (k < LAYOUT_W) begin
         return layout[k];
      end
      return 1'b0;
   endfunction

   // open edges of tile t, bit order N E S W
   function automatic logic [3:0] tile_open(logic [LAYOUT_W-1:0] layout, int t);
      int r;
      int c;
      logic [3:0] m;
      r = t / GRID_SIDE;
      c = t % GRID_SIDE;
      m = 4'b0000;
      if (r > 0)             m[DIR_N] = !wall_at(layout, (r - 1) * GRID_SIDE + c);
      if (r < GRID_SIDE - 1) m[DIR_S] = !wall_at(layout, r * GRID_SIDE + c);
      if (c < GRID_SIDE - 1) m[DIR_E] = !wall_at(layout, VERT_BITS + c * GRID_SIDE + r);
      if (c > 0)             m[DIR_W] = !wall_at(layout, VERT_BITS + (c - 1) * GRID_SIDE + r);
      return m;
   endfunction

   function automatic logic [PEAK_W-1:0] sat_load(load_type v);
      if (int'(v) > (1 << PEAK_W) - 1) begin
         return {PEAK_W{1'b1}};
      end
      return PEAK_W'(v);
   endfunction

endpackage

// ===== rtl/wgrl_if.sv =====
// ----------------------------------------------------------------------------
// wgrl_req_if / wgrl_rsp_if
// Valid/ready channels for wall layouts and route load results.
// ----------------------------------------------------------------------------
interface wgrl_req_if;
   logic                          valid;
   logic                          ready;
   logic [wgrl_pkg::LAYOUT_W-1:0] wall_layout;
   modport source (output valid, output wall_layout, input ready);
   modport sink   (input valid, input wall_layout, output ready);
endinterface

interface wgrl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          connected;
   logic [wgrl_pkg::REACH_W-1:0]  tiles_reached;
   logic [wgrl_pkg::PEAK_W-1:0]   layout_peak_load;
   logic [wgrl_pkg::PEAK_W-1:0]   overall_peak_load;
   logic [wgrl_pkg::LAYOUT_W-1:0] overall_peak_layout;
   modport source (output valid, output connected, output tiles_reached,
                   output layout_peak_load, output overall_peak_load,
                   output overall_peak_layout, input ready);
   modport sink   (input valid, input connected, input tiles_reached,
                   input layout_peak_load, input overall_peak_load,
                   input overall_peak_layout, output ready);
endinterface

// ===== rtl/wgrl_cell.sv =====
// ----------------------------------------------------------------------------
// wgrl_cell
// One grid tile: hop distance to the current destination, next hop, subtree
// count of the route tree and the accumulated entry load.
// ----------------------------------------------------------------------------
module wgrl_cell (
   input  logic                           clock,
   input  wgrl_pkg::cell_cmd_type         cmd,
   input  logic [wgrl_pkg::TILE_W-1:0]    tile_id,
   input  logic [3:0]                     open_mask,
   input  wgrl_pkg::dist_type [3:0]       nbr_dist,
   input  wgrl_pkg::hop_type  [3:0]       nbr_hop,
   input  wgrl_pkg::cnt_type  [3:0]       nbr_cnt,
   output wgrl_pkg::dist_type             distance,
   output wgrl_pkg::hop_type              hop,
   output wgrl_pkg::cnt_type              cnt,
   output wgrl_pkg::load_type             load
);

   wgrl_pkg::dist_type dist_ff, dist_in;
   wgrl_pkg::cnt_type  cnt_ff, cnt_in;
   wgrl_pkg::load_type load_ff, load_in;
   wgrl_pkg::dist_type relax_best;
   wgrl_pkg::dist_type hop_best;
   wgrl_pkg::hop_type  hop_pick;
   wgrl_pkg::cnt_type  child_sum;
   logic [wgrl_pkg::DIST_W:0] cand;

   always_comb begin
      relax_best = dist_ff;
      hop_best   = wgrl_pkg::dist_type'(wgrl_pkg::FAR_HOPS);
      hop_pick   = '0;
      child_sum  = wgrl_pkg::cnt_type'(1);
      for (int d = 0; d < 4; d++) begin
         cand = {1'b0, nbr_dist[d]} + 1'b1;
         if (open_mask[d] && cand < {1'b0, relax_best}) begin
            relax_best = cand[wgrl_pkg::DIST_W-1:0];
         end
         if (open_mask[d] && nbr_dist[d] < hop_best) begin
            hop_best       = nbr_dist[d];
            hop_pick.valid = 1'b1;
            hop_pick.dir   = 2'(d);
         end
         if (open_mask[d] && nbr_hop[d].valid && nbr_hop[d].dir == (2'(d) ^ 2'd2)) begin
            child_sum = child_sum + nbr_cnt[d];
         end
      end
      if (dist_ff == '0) begin
         hop_pick.valid = 1'b0;
      end
   end

   always_comb begin
      dist_in = dist_ff;
      cnt_in  = cnt_ff;
      load_in = load_ff;
      unique case (cmd.op)
         wgrl_pkg::OP_START, wgrl_pkg::OP_INIT: begin
            dist_in = (tile_id == cmd.dest) ? '0
                    : wgrl_pkg::dist_type'(wgrl_pkg::FAR_HOPS);
            cnt_in  = wgrl_pkg::cnt_type'(1);
            if (cmd.op == wgrl_pkg::OP_START) begin
               load_in = '0;
            end
         end
         wgrl_pkg::OP_RELAX: begin
            dist_in = relax_best;
            cnt_in  = wgrl_pkg::cnt_type'(1);
         end
         wgrl_pkg::OP_COUNT: cnt_in  = child_sum;
         wgrl_pkg::OP_ACC:   load_in = load_ff + wgrl_pkg::load_type'(cnt_ff - 1'b1);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      cnt_ff  <= cnt_in;
      load_ff <= load_in;
   end

   assign distance = dist_ff;
   assign hop      = hop_pick;
   assign cnt      = cnt_ff;
   assign load     = load_ff;

endmodule

// ===== rtl/walled_grid_route_load.sv =====
// ----------------------------------------------------------------------------
// walled_grid_route_load
// Flood fill, shortest-path routing and peak tile load of a walled grid.
// ----------------------------------------------------------------------------
// One layout is in work at a time. A grid of tile cells relaxes hop distances
// to one destination per round, then counts route-tree subtrees to add each
// tile's entries. The result waits in its output register until transferred,
// and the next layout is taken after.
module walled_grid_route_load (
   input  logic       clock,
   input  logic       reset,
   wgrl_req_if.sink   req_chan,
   wgrl_rsp_if.source rsp_chan
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FLOOD  = 4'd1;
   localparam logic [3:0] S_CHECK  = 4'd2;
   localparam logic [3:0] S_INIT   = 4'd3;
   localparam logic [3:0] S_RELAX  = 4'd4;
   localparam logic [3:0] S_COUNT  = 4'd5;
   localparam logic [3:0] S_ACC    = 4'd6;
   localparam logic [3:0] S_SWEEP  = 4'd7;
   localparam logic [3:0] S_FINISH = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   localparam int TILES = wgrl_pkg::TILES;
   localparam int SIDE  = wgrl_pkg::GRID_SIDE;

   logic [3:0]                      state_ff, state_in;
   logic [wgrl_pkg::TILE_W-1:0]     round_ff, round_in;
   logic [wgrl_pkg::TILE_W-1:0]     dest_ff, dest_in;
   logic [wgrl_pkg::LAYOUT_W-1:0]   layout_ff, layout_in;
   logic                            conn_ff, conn_in;
   logic [wgrl_pkg::REACH_W-1:0]    tiles_ff, tiles_in;
   wgrl_pkg::load_type              lpeak_ff, lpeak_in;
   wgrl_pkg::load_type              peak_ff, peak_in;
   logic [wgrl_pkg::LAYOUT_W-1:0]   peak_layout_ff, peak_layout_in;

   wgrl_pkg::cell_cmd_type          cmd;
   wgrl_pkg::dist_type [TILES-1:0]  dist_vec;
   wgrl_pkg::hop_type  [TILES-1:0]  hop_vec;
   wgrl_pkg::cnt_type  [TILES-1:0]  cnt_vec;
   wgrl_pkg::load_type [TILES-1:0]  load_vec;
   logic [TILES-1:0]                reached_vec;
   logic [wgrl_pkg::CNT_W-1:0]      reached_cnt;
   logic                            round_last;

   for (genvar t = 0; t < TILES; t++) begin : g_tile
      localparam int R  = t / SIDE;
      localparam int C  = t % SIDE;
      localparam int TN = (R > 0) ? t - SIDE : t;
      localparam int TE = (C < SIDE - 1) ? t + 1 : t;
      localparam int TS = (R < SIDE - 1) ? t + SIDE : t;
      localparam int TW = (C > 0) ? t - 1 : t;

      logic [3:0] open_mask;
      assign open_mask = wgrl_pkg::tile_open(layout_ff, t);

      wgrl_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .tile_id   (wgrl_pkg::TILE_W'(t)),
         .open_mask (open_mask),
         .nbr_dist  ({dist_vec[TW], dist_vec[TS], dist_vec[TE], dist_vec[TN]}),
         .nbr_hop   ({hop_vec[TW], hop_vec[TS], hop_vec[TE], hop_vec[TN]}),
         .nbr_cnt   ({cnt_vec[TW], cnt_vec[TS], cnt_vec[TE], cnt_vec[TN]}),
         .distance  (dist_vec[t]),
         .hop       (hop_vec[t]),
         .cnt       (cnt_vec[t]),
         .load      (load_vec[t])
      );

      assign reached_vec[t] = dist_vec[t] != wgrl_pkg::dist_type'(wgrl_pkg::FAR_HOPS);
   end

   assign reached_cnt = wgrl_pkg::CNT_W'($countones(reached_vec));
   assign round_last  = int'(round_ff) == TILES - 1;

   always_comb begin
      state_in       = state_ff;
      round_in       = round_ff;
      dest_in        = dest_ff;
      layout_in      = layout_ff;
      conn_in        = conn_ff;
      tiles_in       = tiles_ff;
      lpeak_in       = lpeak_ff;
      peak_in        = peak_ff;
      peak_layout_in = peak_layout_ff;
      cmd.op         = wgrl_pkg::OP_HOLD;
      cmd.dest       = dest_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               layout_in = req_chan.wall_layout;
               cmd.op    = wgrl_pkg::OP_START;
               cmd.dest  = '0;
               round_in  = '0;
               state_in  = S_FLOOD;
            end
         end
         S_FLOOD: begin
            cmd.op   = wgrl_pkg::OP_RELAX;
            round_in = round_ff + 1'b1;
            if (round_last) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (int'(reached_cnt) == TILES) begin
               dest_in  = '0;
               state_in = S_INIT;
            end else begin
               conn_in  = 1'b0;
               tiles_in = (int'(reached_cnt) > 31) ? 5'd31 : wgrl_pkg::REACH_W'(reached_cnt);
               lpeak_in = '0;
               state_in = S_DONE;
            end
         end
         S_INIT: begin
            cmd.op   = wgrl_pkg::OP_INIT;
            round_in = '0;
            state_in = S_RELAX;
         end
         S_RELAX: begin
            cmd.op   = wgrl_pkg::OP_RELAX;
            round_in = round_ff + 1'b1;
            if (round_last) begin
               round_in = '0;
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            cmd.op   = wgrl_pkg::OP_COUNT;
            round_in = round_ff + 1'b1;
            if (round_last) state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op = wgrl_pkg::OP_ACC;
            if (int'(dest_ff) == TILES - 1) begin
               round_in = '0;
               lpeak_in = '0;
               state_in = S_SWEEP;
            end else begin
               dest_in  = dest_ff + 1'b1;
               state_in = S_INIT;
            end
         end
         S_SWEEP: begin
            if (load_vec[round_ff] > lpeak_ff) lpeak_in = load_vec[round_ff];
            round_in = round_ff + 1'b1;
            if (round_last) state_in = S_FINISH;
         end
         S_FINISH: begin
            conn_in  = 1'b1;
            tiles_in = (TILES > 31) ? 5'd31 : wgrl_pkg::REACH_W'(TILES);
            if (lpeak_ff > peak_ff) begin
               peak_in        = lpeak_ff;
               peak_layout_in = layout_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_chan.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         peak_ff        <= '0;
         peak_layout_ff <= '0;
      end else begin
         state_ff       <= state_in;
         peak_ff        <= peak_in;
         peak_layout_ff <= peak_layout_in;
      end
      round_ff  <= round_in;
      dest_ff   <= dest_in;
      layout_ff <= layout_in;
      conn_ff   <= conn_in;
      tiles_ff  <= tiles_in;
      lpeak_ff  <= lpeak_in;
   end

   assign req_chan.ready               = state_ff == S_IDLE;
   assign rsp_chan.valid               = state_ff == S_DONE;
   assign rsp_chan.connected           = conn_ff;
   assign rsp_chan.tiles_reached       = tiles_ff;
   assign rsp_chan.layout_peak_load    = wgrl_pkg::sat_load(lpeak_ff);
   assign rsp_chan.overall_peak_load   = wgrl_pkg::sat_load(peak_ff);
   assign rsp_chan.overall_peak_layout = peak_layout_ff;

`ifndef SYNTHESIS
   a_unconn_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.connected) |-> rsp_chan.layout_peak_load == '0)
      else $error("unconnected layout reports nonzero load");
   a_peak_order: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.overall_peak_load >= rsp_chan.layout_peak_load)
      else $error("overall peak below layout peak");
   a_conn_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.connected) |-> int'(tiles_ff) == TILES)
      else $error("connected layout without all tiles reached");
`endif

endmodule
